// ===== design/byte_memory_fetch_load_store_macros.svh =====
// Assertion macros for the byte memory with fetch and load/store ports.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef BYTE_MEMORY_FETCH_LOAD_STORE_MACROS_SVH
`define BYTE_MEMORY_FETCH_LOAD_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMFLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bmfls_pkg.sv =====
// Shared types and constants of the byte memory with fetch and load/store ports.
// No dependencies; imported by bmfls_assemble and the top level.
`default_nettype none

package bmfls_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_SET_PTR = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_CYCLE   = 2'd2;

  // Load size codes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Fixed field widths of the stream payload.
  localparam int unsigned FIELD_ADDR_W = 20;
  localparam int unsigned WORD_W       = 32;

  // Input tdata layout, lowest field first.
  localparam int unsigned IMG_ADDR_LSB = 0;
  localparam int unsigned IMG_BYTE_LSB = 20;
  localparam int unsigned STALL_BIT    = 28;
  localparam int unsigned PC_LSB       = 29;
  localparam int unsigned REQ_VAL_BIT  = 49;
  localparam int unsigned REQ_ST_BIT   = 50;
  localparam int unsigned SIZE_LSB     = 51;
  localparam int unsigned REQ_ADDR_LSB = 53;
  localparam int unsigned SDATA_LSB    = 73;
  localparam int unsigned LANES_LSB    = 105;
  localparam int unsigned IN_TDATA_W   = 112;
  localparam int unsigned OUT_TDATA_W  = 72;

  // Control carried from the accept cycle to the cycle the read data returns.
  typedef struct packed {
    logic       fetch;       // a new instruction word is read
    logic       resp_valid;  // a request is served
    logic       resp_store;  // the served request is a store
    logic [1:0] size;        // load size code
    logic [1:0] pc_off;      // byte offset of the fetch address
    logic [1:0] addr_off;    // byte offset of the request address
  } bmfls_ctl_t;

endpackage

`default_nettype wire

// ===== design/bmfls_bank.sv =====
// One byte-wide memory bank: one write port and two registered read ports.
// No dependencies; four of them are instantiated by the top level.
`default_nettype none

module bmfls_bank #(
  parameter int unsigned ROW_BITS = 18
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ROW_BITS-1:0] waddr_i,
  input  wire logic [7:0]          wdata_i,
  input  wire logic                re_i,
  input  wire logic [ROW_BITS-1:0] fa_addr_i,
  input  wire logic [ROW_BITS-1:0] la_addr_i,
  output logic      [7:0]          fa_data_o,
  output logic      [7:0]          la_data_o
);

  logic [7:0] mem_q [2**ROW_BITS];
  logic [7:0] fa_data_q;
  logic [7:0] la_data_q;

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      fa_data_q <= mem_q[fa_addr_i];
      la_data_q <= mem_q[la_addr_i];
    end
  end

  assign fa_data_o = fa_data_q;
  assign la_data_o = la_data_q;

endmodule

`default_nettype wire

// ===== design/bmfls_assemble.sv =====
// Rotates the four bank bytes into little-endian words and masks the load size.
// Depends on bmfls_pkg.
`default_nettype none

module bmfls_assemble
  import bmfls_pkg::*;
(
  input  wire bmfls_ctl_t        ctl_i,
  input  wire logic [WORD_W-1:0] held_i,
  input  wire logic [3:0][7:0]   fetch_bytes_i,
  input  wire logic [3:0][7:0]   load_bytes_i,
  output logic      [WORD_W-1:0] instr_o,
  output logic      [WORD_W-1:0] load_data_o
);

  logic [WORD_W-1:0] fetch_word;
  logic [WORD_W-1:0] load_word;

  // Byte i of a word sits in the bank that follows the address offset by i.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fetch_word[8*i +: 8] = fetch_bytes_i[2'(ctl_i.pc_off + 2'(i))];
      load_word[8*i +: 8]  = load_bytes_i[2'(ctl_i.addr_off + 2'(i))];
    end
  end

  assign instr_o = ctl_i.fetch ? fetch_word : held_i;

  // Only served loads return data; the upper bytes are zeroed by size.
  always_comb begin
    load_data_o = '0;
    if (ctl_i.resp_valid && !ctl_i.resp_store) begin
      unique case (ctl_i.size)
        SIZE_BYTE: load_data_o = {24'd0, load_word[7:0]};
        SIZE_HALF: load_data_o = {16'd0, load_word[15:0]};
        SIZE_WORD: load_data_o = load_word;
        default:   load_data_o = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/byte_memory_fetch_load_store.sv =====
// Top level of the byte memory with image loader, fetch port and load/store port.
// Depends on bmfls_pkg, bmfls_bank, bmfls_assemble and the assertion macros header.
//
//   channel  | direction | tdata                                   | tuser
//   s_axis   | in        | loader, fetch and bus request fields    | item kind
//   m_axis   | out       | instruction, response_valid, load_data  | response_is_store
//
// An accepted beat reads all four byte banks at its edge; the result is formed
// from the registered bank data on the next edge, and the next beat is taken in
// the cycle its result leaves the output register.
// Stores and preload bytes are written at the accept edge, after the reads.
// After reset a clearing pass zeroes the memory, one row of four bytes per cycle,
// from row 0 through the last row; no beat is accepted until it ends.
// A stalled output holds its beat and blocks further input.
`default_nettype none

`include "byte_memory_fetch_load_store_macros.svh"

module byte_memory_fetch_load_store
  import bmfls_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 20
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // image_address, image_byte, fetch_stall, fetch_pc, request_valid,
  // request_is_store, load_size, request_address, store_data, store_lanes
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  wire logic [1:0]             s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // instruction, response_valid, load_data
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // response_is_store
  output logic                        m_axis_tuser_o
);

  localparam int unsigned ROW_BITS = ADDR_BITS - 2;
  localparam logic [ROW_BITS-1:0] LAST_ROW = '1;

  // Controller states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [ROW_BITS-1:0]  clr_q, clr_d;
  logic [ADDR_BITS-1:0] ptr_q, ptr_d;
  logic                 pend_q, pend_d;
  logic [WORD_W-1:0]    held_q;
  bmfls_ctl_t           ctl_q, ctl_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_W-1:0]    out_instr_q;
  logic                 out_rv_q;
  logic                 out_rs_q;
  logic [WORD_W-1:0]    out_ld_q;

  // Input field unpacking.
  logic [1:0]              in_kind;
  logic [FIELD_ADDR_W-1:0] img_addr;
  logic [7:0]              img_byte;
  logic                    stall;
  logic [FIELD_ADDR_W-1:0] pc_field;
  logic                    req_valid;
  logic                    req_store;
  logic [1:0]              size;
  logic [FIELD_ADDR_W-1:0] req_field;
  logic [WORD_W-1:0]       sdata;
  logic [3:0]              lanes;

  assign in_kind   = s_axis_tuser_i;
  assign img_addr  = s_axis_tdata_i[IMG_ADDR_LSB +: FIELD_ADDR_W];
  assign img_byte  = s_axis_tdata_i[IMG_BYTE_LSB +: 8];
  assign stall     = s_axis_tdata_i[STALL_BIT];
  assign pc_field  = s_axis_tdata_i[PC_LSB +: FIELD_ADDR_W];
  assign req_valid = s_axis_tdata_i[REQ_VAL_BIT];
  assign req_store = s_axis_tdata_i[REQ_ST_BIT];
  assign size      = s_axis_tdata_i[SIZE_LSB +: 2];
  assign req_field = s_axis_tdata_i[REQ_ADDR_LSB +: FIELD_ADDR_W];
  assign sdata     = s_axis_tdata_i[SDATA_LSB +: WORD_W];
  assign lanes     = s_axis_tdata_i[LANES_LSB +: 4];

  // Addresses reduced to the memory size.
  logic [ADDR_BITS-1:0] pc_a;
  logic [ADDR_BITS-1:0] req_a;
  assign pc_a  = ADDR_BITS'(pc_field);
  assign req_a = ADDR_BITS'(req_field);

  // Handshake and decode of the current beat.
  logic accept;
  logic is_cycle;
  logic serve;
  logic serve_store;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_cycle        = (in_kind == KIND_CYCLE);
  assign serve           = is_cycle && pend_q && req_valid;
  assign serve_store     = serve && req_store;

  // Byte banks: bank b holds the bytes whose address ends in b.
  logic [3:0][7:0] fetch_bytes;
  logic [3:0][7:0] load_bytes;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BANK = 2'(b);

    logic [ROW_BITS-1:0] f_row;
    logic [ROW_BITS-1:0] l_row;
    logic [ROW_BITS-1:0] w_row;
    logic                w_en;
    logic [7:0]          w_byte;
    logic [1:0]          lane;

    // A word that starts past this bank's slot wraps into the next row.
    assign f_row = pc_a[ADDR_BITS-1:2] + ROW_BITS'(BANK < pc_a[1:0]);
    assign l_row = req_a[ADDR_BITS-1:2] + ROW_BITS'(BANK < req_a[1:0]);
    assign lane  = BANK - req_a[1:0];

    // Write port: clearing pass, preload byte or store lane.
    always_comb begin
      w_en   = 1'b0;
      w_row  = l_row;
      w_byte = sdata[{lane, 3'b000} +: 8];
      priority if (state_q == ST_CLEAR) begin
        w_en   = 1'b1;
        w_row  = clr_q;
        w_byte = '0;
      end else if (accept && (in_kind == KIND_BYTE)) begin
        w_en   = (ptr_q[1:0] == BANK);
        w_row  = ptr_q[ADDR_BITS-1:2];
        w_byte = img_byte;
      end else if (accept && serve_store) begin
        w_en   = lanes[lane];
      end else begin
        w_en   = 1'b0;
      end
    end

    bmfls_bank #(
      .ROW_BITS(ROW_BITS)
    ) u_bank (
      .clk_i    (clk_i),
      .we_i     (w_en),
      .waddr_i  (w_row),
      .wdata_i  (w_byte),
      .re_i     (accept),
      .fa_addr_i(f_row),
      .la_addr_i(l_row),
      .fa_data_o(fetch_bytes[b]),
      .la_data_o(load_bytes[b])
    );
  end

  // Result assembly from the registered bank data.
  logic [WORD_W-1:0] instr;
  logic [WORD_W-1:0] load_data;

  bmfls_assemble u_assemble (
    .ctl_i        (ctl_q),
    .held_i       (held_q),
    .fetch_bytes_i(fetch_bytes),
    .load_bytes_i (load_bytes),
    .instr_o      (instr),
    .load_data_o  (load_data)
  );

  // Next-state logic of the controller and the loader and bus state.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    ctl_d       = ctl_q;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ROW_BITS'(1);
        if (clr_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
          ctl_d.fetch      = is_cycle && !stall;
          ctl_d.resp_valid = serve;
          ctl_d.resp_store = serve_store;
          ctl_d.size       = size;
          ctl_d.pc_off     = pc_a[1:0];
          ctl_d.addr_off   = req_a[1:0];
          priority if (in_kind == KIND_SET_PTR) begin
            ptr_d = ADDR_BITS'(img_addr);
          end else if (in_kind == KIND_BYTE) begin
            ptr_d = ptr_q + ADDR_BITS'(1);
          end else if (is_cycle) begin
            pend_d = pend_q ? 1'b0 : req_valid;
          end else begin
            // An unused kind leaves the loader and bus state alone.
            pend_d = pend_q;
          end
        end
      end
      ST_READ: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_READ) begin
        held_q <= instr;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_d;
    if (state_q == ST_READ) begin
      out_instr_q <= instr;
      out_rv_q    <= ctl_q.resp_valid;
      out_rs_q    <= ctl_q.resp_store;
      out_ld_q    <= load_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_ld_q, out_rv_q, out_instr_q};
  assign m_axis_tuser_o  = out_rs_q;

  // Checks on the controller and the result.
  `BMFLS_ASSERT_NOW(a_no_accept_in_clear, state_q == ST_CLEAR, !s_axis_tready_o, "beat accepted during clearing pass")
  `BMFLS_ASSERT_NEXT(a_accept_reads, accept, state_q == ST_READ && !out_valid_q, "accepted beat did not start a read")
  `BMFLS_ASSERT_NEXT(a_read_gives_beat, state_q == ST_READ, m_axis_tvalid_o, "read cycle gave no result beat")
  `BMFLS_ASSERT_NEXT(a_pending_once, accept && is_cycle && pend_q, !pend_q, "pending request not retired")
  `BMFLS_ASSERT_NOW(a_store_resp, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[32] && (m_axis_tdata_o[64:33] == 32'd0), "store response malformed")

endmodule

`default_nettype wire
